// ----- rtl/scfifo_pkg.sv -----
// Shared types and codes for the sortable circular FIFO.
// Holds the command and result word formats and the sort sequencer states.
// No dependencies.
package scfifo_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 4;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SERVE  = 2'd1,
    OP_SORT   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SS_IDLE,
    SS_LOAD,
    SS_SCAN,
    SS_FLUSH,
    SS_EMIT
  } sort_state_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [WORD_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    status_t                  status;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;
  } result_t;

endpackage

// ----- rtl/sortable_circular_fifo.sv -----
// Sortable circular FIFO: top level, word store and sort sequencer.
// Depends on scfifo_pkg for the command/result word types and state codes.
//
// Latency: append, serve, no-op and error words give one result word in the
// cycle after start. Append and serve accept one word per cycle (busy low).
// A sort of n >= 2 held words runs n-1 bubble passes over the word store,
// each pass a load step, a scan over its words and a flush step, then streams
// the n words out one per cycle; the word store has one read and one write port.
// Reset: rst (synchronous) empties the queue; stored words stay undefined.
// Results cannot be stalled: each strobe marks a word valid for one cycle.
module sortable_circular_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  scfifo_pkg::item_t     item,
  output logic                  strobe,
  output scfifo_pkg::result_t   result
);
  import scfifo_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Word store: one write and one registered read per cycle.
  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [WORD_W-1:0] wr_data;

  // Queue pointers.
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;

  // Sort sequencer.
  sort_state_t              state;
  sort_state_t              state_next;
  logic [CW-1:0]            pos;
  logic [CW-1:0]            span;
  logic                     first;
  logic signed [WORD_W-1:0] carry;

  // Result registers; data comes straight from the store read when res_mem.
  logic             res_mem;
  status_t          res_status;
  logic             res_last;
  logic [CW-1:0]    res_occ;

  logic             accept;
  logic             is_full;
  logic             is_empty;
  logic [CW-1:0]    pos_back;
  logic [CW-1:0]    span_back;
  logic             carry_greater;

  // Map a queue position onto a slot of the ring.
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign busy          = (state != SS_IDLE);
  assign accept        = start && (state == SS_IDLE);
  assign is_full       = (count >= CW'(DEPTH));
  assign is_empty      = (count == '0);
  assign pos_back      = pos - CW'(2);
  assign span_back     = span - CW'(1);
  assign carry_greater = (carry > rd_data);

  assign result.data      = res_mem ? rd_data : '0;
  assign result.status    = res_status;
  assign result.last      = res_last;
  assign result.occupancy = OCC_W'(res_occ);

  // Word store.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Next state of the sort sequencer.
  always_comb begin
    state_next = state;
    case (state)
      SS_IDLE: begin
        if (accept && (item.operation == OP_SORT)) begin
          if (count >= CW'(2)) begin
            state_next = SS_LOAD;
          end else if (count == CW'(1)) begin
            state_next = SS_EMIT;
          end
        end
      end
      SS_LOAD:  state_next = SS_SCAN;
      SS_SCAN: begin
        if (pos == span) begin
          state_next = SS_FLUSH;
        end
      end
      SS_FLUSH: state_next = (span > CW'(2)) ? SS_LOAD : SS_EMIT;
      SS_EMIT: begin
        if (pos == count - CW'(1)) begin
          state_next = SS_IDLE;
        end
      end
      default:  state_next = SS_IDLE;
    endcase
  end

  // Store port control per state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = item.value;
    case (state)
      SS_IDLE: begin
        rd_en = accept && (item.operation == OP_SERVE) && !is_empty;
        wr_en = accept && (item.operation == OP_APPEND) && !is_full;
      end
      SS_LOAD: begin
        rd_en   = 1'b1;
        rd_addr = ring_slot(head, pos[AW-1:0]);
      end
      SS_SCAN: begin
        // Read the next word while writing back the smaller of the pair.
        rd_en   = (pos != span);
        rd_addr = ring_slot(head, pos[AW-1:0]);
        wr_en   = !first;
        wr_addr = ring_slot(head, pos_back[AW-1:0]);
        wr_data = carry_greater ? rd_data : carry;
      end
      SS_FLUSH: begin
        // Park the pass maximum at the end of the pass.
        wr_en   = 1'b1;
        wr_addr = ring_slot(head, span_back[AW-1:0]);
        wr_data = carry;
      end
      SS_EMIT: begin
        rd_en   = 1'b1;
        rd_addr = ring_slot(head, pos[AW-1:0]);
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // Pointers, sequencer registers and result words.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SS_IDLE;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      pos    <= '0;
      span   <= '0;
      first  <= 1'b0;
      strobe <= 1'b0;
      res_mem <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        SS_IDLE: begin
          if (accept) begin
            strobe     <= 1'b1;
            res_mem    <= 1'b0;
            res_status <= STAT_OK;
            res_last   <= 1'b1;
            res_occ    <= count;
            pos        <= '0;
            span       <= count;
            case (item.operation)
              OP_APPEND: begin
                if (is_full) begin
                  res_status <= STAT_FULL;
                end else begin
                  tail    <= ring_inc(tail);
                  count   <= count + CW'(1);
                  res_occ <= count + CW'(1);
                end
              end
              OP_SERVE: begin
                if (is_empty) begin
                  res_status <= STAT_EMPTY;
                end else begin
                  head    <= ring_inc(head);
                  count   <= count - CW'(1);
                  res_occ <= count - CW'(1);
                  res_mem <= 1'b1;
                end
              end
              OP_SORT: begin
                // Non-empty sort: results come from the emit stream instead.
                if (is_empty) begin
                  res_status <= STAT_EMPTY;
                end else begin
                  strobe <= 1'b0;
                end
              end
              default: begin
                res_status <= STAT_OK;
              end
            endcase
          end
        end
        SS_LOAD: begin
          pos   <= CW'(1);
          first <= 1'b1;
        end
        SS_SCAN: begin
          pos   <= pos + CW'(1);
          first <= 1'b0;
          // Keep the larger word; ties leave the earlier word in front.
          if (first || !carry_greater) begin
            carry <= rd_data;
          end
        end
        SS_FLUSH: begin
          pos  <= '0;
          span <= span_back;
        end
        SS_EMIT: begin
          strobe     <= 1'b1;
          res_mem    <= 1'b1;
          res_status <= STAT_OK;
          res_last   <= (pos == count - CW'(1));
          res_occ    <= count;
          pos        <= pos + CW'(1);
        end
        default: begin
          pos <= '0;
        end
      endcase
    end
  end

endmodule
